@@ rtl/signed_int_to_decimal_ascii_core_defines.svh @@
// Assertion macros shared by the signed integer to decimal ASCII block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, checked at the rising edge, off during reset.
`define SITDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sitda assertion failed");

// Next-cycle implication, checked at the rising edge, off during reset.
`define SITDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sitda assertion failed");

`endif

@@ rtl/sitda_pkg.sv @@
// Package for the signed integer to decimal ASCII block.
// Field widths and character constants; no dependencies.
`timescale 1ns / 1ps

package sitda_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 8;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [CHAR_WIDTH-1:0]  char_type;

   localparam char_type CHAR_ZERO  = 8'd48;
   localparam char_type CHAR_MINUS = 8'd45;

endpackage

@@ rtl/sitda_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

interface sitda_req_if;
   import sitda_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitda_rsp_if;
   import sitda_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_code;
   logic     last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// Channel    Dir  Payload                 Transfer
// req_chan   in   value (32b signed)      valid & ready
// rsp_chan   out  char_code, last_char    valid & ready
//
// Conversion is double dabble: one shift-and-correct step per cycle for each
// bit of the value, then leading zero digits are dropped down to the last one,
// then one character per cycle while rsp takes them, a minus sign first when
// the value is negative.
// req ready only while idle; the last character may still wait in the
// output register while the next value is taken. rsp stalls hold the sequencer.
// Synchronous active-high reset clears state and the output valid.
// Depends on sitda_pkg, sitda_if and the assertion macro header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_defines.svh"

module signed_int_to_decimal_ascii_core #(
   parameter int DATA_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   sitda_req_if.sink   req_chan,
   sitda_rsp_if.source rsp_chan
);
   import sitda_pkg::*;

   localparam int NUM_DIGITS = (DATA_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
   localparam int REM_W      = $clog2(NUM_DIGITS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_type;

   state_type             state_ff, state_in;
   logic [DATA_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      bcd_adj;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   char_type              char_ff, char_in;
   logic                  last_ff, last_in;

   logic [DATA_WIDTH-1:0] v_w;
   logic [DATA_WIDTH-1:0] mag;
   logic [3:0]            top_digit;
   logic                  req_fire;
   logic                  out_free;

   // bits above DATA_WIDTH are dropped; missing bits read as zero
   generate
      if (DATA_WIDTH <= VALUE_WIDTH) begin : g_trunc
         assign v_w = req_chan.value[DATA_WIDTH-1:0];
      end else begin : g_ext
         assign v_w = {{(DATA_WIDTH-VALUE_WIDTH){1'b0}}, req_chan.value};
      end
   endgenerate

   // unsigned magnitude, so the most negative value needs no special case
   assign mag       = v_w[DATA_WIDTH-1] ? (~v_w + DATA_WIDTH'(1)) : v_w;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.char_code = char_ff;
   assign rsp_chan.last_char = last_ff;

   // add-3 correction on every BCD digit of 5 or more
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? (bcd_ff[4*i +: 4] + 4'd3)
                                                         : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               bin_in   = mag;
               neg_in   = v_w[DATA_WIDTH-1];
               bcd_in   = '0;
               cnt_in   = CNT_W'(DATA_WIDTH);
               rem_in   = REM_W'(NUM_DIGITS);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == 4'd0 && rem_ff > REM_W'(1)) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               rem_in = rem_ff - REM_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  char_in = CHAR_MINUS;
                  last_in = 1'b0;
                  neg_in  = 1'b0;
               end else begin
                  char_in = CHAR_ZERO + {4'd0, top_digit};
                  last_in = (rem_ff == REM_W'(1));
                  bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
                  rem_in  = rem_ff - REM_W'(1);
                  if (rem_ff == REM_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   // a transfer starts a conversion
   `SITDA_ASSERT_NEXT(a_accept_conv, clock, reset, req_fire, state_ff == ST_CONV)
   // while converting, only the previous value's last character can be pending
   `SITDA_ASSERT_NOW(a_conv_pending_last, clock, reset,
      (state_ff == ST_CONV) && rsp_valid_ff, last_ff)
   // a minus sign never ends a text
   `SITDA_ASSERT_NOW(a_minus_not_last, clock, reset,
      rsp_valid_ff && (char_ff == CHAR_MINUS), !last_ff)
   // digits remain whenever characters are being sent
   `SITDA_ASSERT_NOW(a_emit_has_digit, clock, reset,
      state_ff == ST_EMIT, rem_ff != '0)

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for signed_int_to_decimal_ascii_core: signed values in, decimal ASCII out.
// Depends on sitda_pkg, sitda_if and the core; a local predictor builds the expected characters.
`timescale 1ns / 1ps

module tb_top;
   import sitda_pkg::*;

   localparam int          RANDOM_VALUES = 500;
   localparam int          CYCLE_LIMIT   = 2000000;
   localparam int          LONG_HOLD     = 500;
   localparam int          DRAIN_CYCLES  = 100;
   localparam int unsigned RADIX         = 10;
   localparam int unsigned POW10 [0:9]   = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                             10000000, 100000000, 1000000000};

   typedef struct packed {
      char_type code;
      logic     last;
   } ascii_char_type;

   localparam int DIRECTED_COUNT = 22;
   localparam value_type DIRECTED_VALUES [DIRECTED_COUNT] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, -32'sd999999999,
      32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd1, -32'sd9, 32'd4567,
      -32'sd1000000000, 32'h7FFF_FFFE, 32'd2000000000
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sitda_req_if req_bus ();
   sitda_rsp_if rsp_bus ();

   signed_int_to_decimal_ascii_core #(.DATA_WIDTH(VALUE_WIDTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   value_type      pending_values [$];
   ascii_char_type text_expected [$];
   ascii_char_type oldest_char;

   int values_sent    = 0;
   int chars_seen     = 0;
   int negative_count = 0;
   int mismatch_count = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   int cycle_count    = 0;
   bit hold_done      = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Decimal text of one value: optional minus, then digits, MSD first.
   function automatic void append_decimal_text(value_type v);
      value_type  mag;
      logic       neg;
      logic [3:0] digits [0:11];
      int         nd;
      neg = v[VALUE_WIDTH-1];
      mag = neg ? (~v + 1'b1) : v;   // most negative value stays 2^31 as unsigned
      nd  = 0;
      do begin
         digits[nd] = 4'(mag % RADIX);
         mag        = mag / RADIX;
         nd++;
      end while (mag != 0);
      if (neg) begin
         text_expected.push_back('{CHAR_MINUS, 1'b0});
         negative_count++;
      end
      for (int i = nd - 1; i >= 0; i--)
         text_expected.push_back('{char_type'(CHAR_ZERO + digits[i]), (i == 0)});
   endfunction

   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic int next_gap();
      if ((values_sent / 64) % 3 == 1)
         return 0;   // back-to-back stretch
      else if ($urandom_range(0, 2) == 0)
         return pick_idle_len();
      else
         return 0;
   endfunction

   // Mostly values spread by digit count, plus raw words, the two extremes and edges around powers of ten.
   function automatic value_type random_value();
      int unsigned r, d, lo, hi, mag;
      bit          neg;
      r   = $urandom_range(0, 99);
      neg = $urandom_range(0, 1);
      if (r < 20)
         return $urandom;
      if (r < 25)
         return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (r < 35) begin
         d   = $urandom_range(0, 9);
         mag = POW10[d] - 1 + $urandom_range(0, 2);
      end else begin
         d   = $urandom_range(1, 10);
         lo  = (d == 1) ? 0 : POW10[d-1];
         hi  = (d == 10) ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : POW10[d] - 1;
         mag = $urandom_range(hi, lo);
      end
      return neg ? value_type'(-mag) : value_type'(mag);
   endfunction

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            append_decimal_text(req_bus.value);
            values_sent <= values_sent + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               req_bus.valid <= 1'b0;
               gap_left      <= gap_left - 1;
            end else if (pending_values.size() > 0) begin
               req_bus.valid <= 1'b1;
               req_bus.value <= pending_values.pop_front();
               gap_left      <= next_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            chars_seen <= chars_seen + 1;
            if (text_expected.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual char %0d last %b",
                        $time, rsp_bus.char_code, rsp_bus.last_char);
               mismatch_count++;
            end else begin
               oldest_char = text_expected.pop_front();
               if (rsp_bus.char_code !== oldest_char.code) begin
                  $display("%0t: char_code expected %0d actual %0d",
                           $time, oldest_char.code, rsp_bus.char_code);
                  mismatch_count++;
               end
               if (rsp_bus.last_char !== oldest_char.last) begin
                  $display("%0t: last_char expected %b actual %b",
                           $time, oldest_char.last, rsp_bus.last_char);
                  mismatch_count++;
               end
            end
         end
         // one long hold-off so the core backs up and stalls req
         if (!hold_done && chars_seen >= 60) begin
            hold_done     <= 1'b1;
            rsp_bus.ready <= 1'b0;
            stall_left    <= LONG_HOLD;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
         end else if ((chars_seen / 300) % 3 != 2 && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= pick_idle_len() - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++)
         pending_values.push_back(DIRECTED_VALUES[i]);
      for (int i = 0; i < RANDOM_VALUES; i++)
         pending_values.push_back(random_value());
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // sample between edges so the driver's updates have settled
      while (pending_values.size() > 0 || req_bus.valid || gap_left > 0
             || text_expected.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (text_expected.size() > 0) begin
         $display("%0t: %0d characters expected but never sent", $time, text_expected.size());
         mismatch_count++;
      end
      $display("Converted %0d values (%0d negative), checked %0d characters,",
               values_sent, negative_count, chars_seen);
      $display("with random gaps on both sides and one long receiver hold-off.");
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sitda_pkg.sv
rtl/sitda_if.sv
rtl/signed_int_to_decimal_ascii_core.sv
test/tb_top.sv
